### rtl/core/pidfd_pkg.sv
// ----------------------------------------------------------------------------
// pidfd_pkg
// Shared types and constants for the PID controller with smoothed derivative.
// ----------------------------------------------------------------------------
package pidfd_pkg;

    // Default parameter values
    localparam int FRAC_BITS_DEF      = 16;
    localparam int TICKS_PER_SEC_DEF  = 1000000;

    // Register file
    localparam int          ADDR_W            = 4;
    localparam int          DATA_W            = 32;
    localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd5000;

    // Serial arithmetic widths
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;

    // Smoothing divisor: (3*old + 2*new) / 5
    localparam logic [DIV_D_W-1:0] SMOOTH_DIV = 32'd5;

    typedef enum logic [1:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_SAMPLE_PERIOD
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] gain_p;
        logic [31:0] gain_i;
        logic [31:0] gain_d;
        logic [31:0] sample_period;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_I,
        S_DIV_I,
        S_MUL_R,
        S_DIV_R,
        S_DIV_S,
        S_MUL_P,
        S_MUL_G,
        S_MUL_D,
        S_OUT
    } t_state;

endpackage

### rtl/core/pidfd_regs.sv
// ----------------------------------------------------------------------------
// pidfd_regs
// APB-style register file: three gains and the sample period.
// ----------------------------------------------------------------------------
module pidfd_regs
    import pidfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p        <= '0;
            r_cfg.gain_i        <= '0;
            r_cfg.gain_d        <= '0;
            r_cfg.sample_period <= SAMPLE_PERIOD_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_GAIN_P:        r_cfg.gain_p        <= pwdata;
                REG_GAIN_I:        r_cfg.gain_i        <= pwdata;
                REG_GAIN_D:        r_cfg.gain_d        <= pwdata;
                REG_SAMPLE_PERIOD: r_cfg.sample_period <= pwdata;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (idx)
            REG_GAIN_P:        prdata = r_cfg.gain_p;
            REG_GAIN_I:        prdata = r_cfg.gain_i;
            REG_GAIN_D:        prdata = r_cfg.gain_d;
            REG_SAMPLE_PERIOD: prdata = r_cfg.sample_period;
            default:           prdata = '0;
        endcase
    end

endmodule

### rtl/core/pidfd_mul.sv
// ----------------------------------------------------------------------------
// pidfd_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pidfd_mul
    import pidfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mul_req           i_req,
    output logic               o_done,
    output logic [MUL_P_W-1:0] o_product
);

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic [MUL_A_W-1:0] r_a;
    logic [MUL_P_W-1:0] r_p;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [MUL_A_W:0]   sum;

    // Add the multiplicand into the upper half when the low bit is set
    assign sum = {1'b0, r_p[MUL_P_W-1:MUL_B_W]} + (r_p[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a   <= i_req.a;
                r_p   <= {{MUL_A_W{1'b0}}, i_req.b};
                r_cnt <= CNT_W'(MUL_B_W);
            end else if (r_cnt != '0) begin
                r_p   <= {sum, r_p[MUL_B_W-1:1]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_p;

endmodule

### rtl/core/pidfd_div.sv
// ----------------------------------------------------------------------------
// pidfd_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidfd_div
    import pidfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_N_W-1:0] r_q;
    logic [DIV_D_W-1:0] r_r;
    logic [DIV_D_W-1:0] r_d;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {r_r, r_q[DIV_N_W-1]};
    assign diff  = trial - {1'b0, r_d};
    assign ge    = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q   <= i_req.dividend;
                r_d   <= i_req.divisor;
                r_r   <= '0;
                r_cnt <= CNT_W'(DIV_N_W);
            end else if (r_cnt != '0) begin
                r_r   <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
                r_q   <= {r_q[DIV_N_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

### rtl/core/pid_with_filtered_derivative_top.sv
// ----------------------------------------------------------------------------
// pid_with_filtered_derivative_top
// PID controller with a smoothed derivative in signed fixed point.
//
//   channel | direction | handshake           | beat
//   input   | in        | i_valid / o_stall   | i_now_us, i_target, i_measured
//   output  | out       | o_valid / i_stall   | o_drive, o_filtered_rate
//   config  | in        | psel/penable/pwrite | paddr, pwdata, prdata
//
// A beat that falls inside the sample period is accepted and dropped without an update.
// An update runs five multiplies and three divides on one serial multiplier and
// one serial divider; with no elapsed time it runs only the smoothing divide and
// the three gain multiplies.
// o_stall is high from acceptance until the result is loaded into the output
// register, which holds while i_stall is high. Reset is synchronous.
// ----------------------------------------------------------------------------
module pid_with_filtered_derivative_top
    import pidfd_pkg::*;
#(
    parameter int FRAC_BITS        = FRAC_BITS_DEF,
    parameter int TICKS_PER_SECOND = TICKS_PER_SEC_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [31:0]       i_now_us,
    input  logic signed [31:0] i_target,
    input  logic signed [31:0] i_measured,
    output logic              o_valid,
    input  logic              i_stall,
    output logic signed [31:0] o_drive,
    output logic signed [31:0] o_filtered_rate
);

    localparam logic signed [63:0] ACC_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN  = -ACC_MAX - 64'sd1;
    localparam logic [MUL_P_W-1:0] TERM_CAP = MUL_P_W'(1) << 60;
    localparam logic signed [62:0] DRV_MAX  = 63'sd2147483647;
    localparam logic signed [62:0] DRV_MIN  = -63'sd2147483648;

    t_cfg     cfg;
    t_state   r_state, n_state;
    logic     r_first;
    t_mul_req mul_req;
    t_div_req div_req;
    logic               mul_done, div_done;
    logic [MUL_P_W-1:0] mul_p;
    logic [DIV_N_W-1:0] div_q;

    // Controller state
    logic [31:0]        r_prev_time;
    logic signed [31:0] r_prev_error;
    logic signed [47:0] r_accum;
    logic signed [31:0] r_prev_rate;

    // Per-update work registers
    logic [31:0]        r_now, r_dt;
    logic signed [31:0] r_e;
    logic signed [61:0] r_raw;
    logic signed [31:0] r_rate;
    logic signed [62:0] r_sum;
    logic               r_out_valid;
    logic signed [31:0] r_drive, r_out_rate;

    logic               accept;
    logic [31:0]        dt_w;
    logic signed [32:0] diff_w;
    logic signed [31:0] e_sat;
    logic [31:0]        e_mag, gp_mag, gi_mag, gd_mag, rate_mag;
    logic signed [32:0] de;
    logic [32:0]        de_mag;
    logic [47:0]        acc_mag;
    logic signed [62:0] pr63, s_w;
    logic [62:0]        s_mag;
    logic               out_free;
    logic               term_neg;
    logic [MUL_P_W-1:0] pm;
    logic [60:0]        tm;
    logic signed [62:0] term;
    logic signed [63:0] inc64, acc64;
    logic [61:0]        q62;

    pidfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pidfd_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mul_req),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    pidfd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Input side
    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign dt_w    = i_now_us - r_prev_time;
    assign diff_w  = {i_target[31], i_target} - {i_measured[31], i_measured};
    assign e_sat   = (diff_w[32] != diff_w[31]) ?
                     (diff_w[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : diff_w[31:0];

    // Magnitudes of the operands
    assign e_mag    = r_e[31] ? (~r_e + 32'd1) : r_e;
    assign de       = {r_e[31], r_e} - {r_prev_error[31], r_prev_error};
    assign de_mag   = de[32] ? (~de + 33'd1) : de;
    assign gp_mag   = cfg.gain_p[31] ? (~cfg.gain_p + 32'd1) : cfg.gain_p;
    assign gi_mag   = cfg.gain_i[31] ? (~cfg.gain_i + 32'd1) : cfg.gain_i;
    assign gd_mag   = cfg.gain_d[31] ? (~cfg.gain_d + 32'd1) : cfg.gain_d;
    assign acc_mag  = r_accum[47] ? (~r_accum + 48'd1) : r_accum;
    assign rate_mag = r_rate[31] ? (~r_rate + 32'd1) : r_rate;

    // Smoothing sum 3*old + 2*raw
    assign pr63  = 63'(r_prev_rate);
    assign s_w   = pr63 + (pr63 <<< 1) + {r_raw, 1'b0};
    assign s_mag = s_w[62] ? (~s_w + 63'd1) : s_w;

    // Gain term: product >> FRAC_BITS, capped
    assign pm   = mul_p >> FRAC_BITS;
    assign tm   = (pm > TERM_CAP) ? TERM_CAP[60:0] : pm[60:0];
    assign term = term_neg ? -$signed(63'(tm)) : $signed(63'(tm));

    // Integral increment
    assign inc64 = r_e[31] ? -$signed(div_q) : $signed(div_q);
    assign acc64 = 64'(r_accum) + inc64;
    assign q62   = div_q[61:0];

    assign out_free = !r_out_valid || !i_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && dt_w >= cfg.sample_period) begin
                    n_state = (dt_w == '0) ? S_DIV_S : S_MUL_I;
                end
            end
            S_MUL_I: if (mul_done) n_state = S_DIV_I;
            S_DIV_I: if (div_done) n_state = S_MUL_R;
            S_MUL_R: if (mul_done) n_state = S_DIV_R;
            S_DIV_R: if (div_done) n_state = S_DIV_S;
            S_DIV_S: if (div_done) n_state = S_MUL_P;
            S_MUL_P: if (mul_done) n_state = S_MUL_G;
            S_MUL_G: if (mul_done) n_state = S_MUL_D;
            S_MUL_D: if (mul_done) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Unit requests, issued on the first cycle of each multiply or divide state
    always_comb begin
        mul_req  = '0;
        div_req  = '0;
        term_neg = 1'b0;
        unique case (r_state)
            S_MUL_I: begin
                mul_req.start = r_first;
                mul_req.a     = MUL_A_W'(r_dt);
                mul_req.b     = MUL_B_W'(e_mag);
            end
            S_DIV_I: begin
                div_req.start    = r_first;
                div_req.dividend = mul_p[DIV_N_W-1:0];
                div_req.divisor  = DIV_D_W'(TICKS_PER_SECOND);
            end
            S_MUL_R: begin
                mul_req.start = r_first;
                mul_req.a     = MUL_A_W'(TICKS_PER_SECOND);
                mul_req.b     = de_mag;
            end
            S_DIV_R: begin
                div_req.start    = r_first;
                div_req.dividend = mul_p[DIV_N_W-1:0];
                div_req.divisor  = r_dt;
            end
            S_DIV_S: begin
                div_req.start    = r_first;
                div_req.dividend = DIV_N_W'(s_mag);
                div_req.divisor  = SMOOTH_DIV;
            end
            S_MUL_P: begin
                mul_req.start = r_first;
                mul_req.a     = MUL_A_W'(e_mag);
                mul_req.b     = MUL_B_W'(gp_mag);
                term_neg      = cfg.gain_p[31] ^ r_e[31];
            end
            S_MUL_G: begin
                mul_req.start = r_first;
                mul_req.a     = acc_mag;
                mul_req.b     = MUL_B_W'(gi_mag);
                term_neg      = cfg.gain_i[31] ^ r_accum[47];
            end
            S_MUL_D: begin
                mul_req.start = r_first;
                mul_req.a     = MUL_A_W'(rate_mag);
                mul_req.b     = MUL_B_W'(gd_mag);
                term_neg      = cfg.gain_d[31] ^ r_rate[31];
            end
            default: begin
                mul_req  = '0;
                div_req  = '0;
                term_neg = 1'b0;
            end
        endcase
    end

    // State register and first-cycle flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= (n_state != r_state);
        end
    end

    // Datapath and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time  <= '0;
            r_prev_error <= '0;
            r_accum      <= '0;
            r_prev_rate  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // Load a new result beat, or drop the one taken by the receiver
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_now <= i_now_us;
                        r_dt  <= dt_w;
                        r_e   <= e_sat;
                        r_raw <= '0;
                        r_sum <= '0;
                    end
                end
                S_DIV_I: begin
                    if (div_done) begin
                        if (acc64 > ACC_MAX) begin
                            r_accum <= ACC_MAX[47:0];
                        end else if (acc64 < ACC_MIN) begin
                            r_accum <= ACC_MIN[47:0];
                        end else begin
                            r_accum <= acc64[47:0];
                        end
                    end
                end
                S_DIV_R: begin
                    if (div_done) begin
                        r_raw <= de[32] ? (~q62 + 62'd1) : q62;
                    end
                end
                S_DIV_S: begin
                    if (div_done) begin
                        if (s_w[62]) begin
                            r_rate <= (div_q > 64'h8000_0000) ? 32'sh8000_0000 :
                                      (~div_q[31:0] + 32'd1);
                        end else begin
                            r_rate <= (div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF :
                                      div_q[31:0];
                        end
                    end
                end
                S_MUL_P, S_MUL_G, S_MUL_D: begin
                    if (mul_done) begin
                        r_sum <= r_sum + term;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_rate   <= r_rate;
                        if (r_sum > DRV_MAX) begin
                            r_drive <= 32'sh7FFF_FFFF;
                        end else if (r_sum < DRV_MIN) begin
                            r_drive <= 32'sh8000_0000;
                        end else begin
                            r_drive <= r_sum[31:0];
                        end
                        r_prev_time  <= r_now;
                        r_prev_error <= r_e;
                        r_prev_rate  <= r_rate;
                    end
                end
                default: begin
                    r_sum <= r_sum;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_drive         = r_drive;
    assign o_filtered_rate = r_out_rate;

endmodule

### rtl/core/pidfd_chk.sv
// ----------------------------------------------------------------------------
// pidfd_chk
// Port-level checks for the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidfd_chk
    import pidfd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic signed [31:0] o_drive,
    input logic signed [31:0] o_filtered_rate
);

    // Reset leaves no result pending and the input open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result or stall left after reset");

    // Busy only after an input beat was offered
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid))
        else $error("input stalled without a beat");

    // A fresh result only follows a busy period
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a busy period");

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_drive) && $stable(o_filtered_rate))
        else $error("stalled result changed");

endmodule

bind pid_with_filtered_derivative_top pidfd_chk u_pidfd_chk (.*);
